[src/bspline_de_boor_evaluator_macros.svh]
// assertion macros for the b-spline evaluator
`ifndef BSPLINE_DE_BOOR_EVALUATOR_MACROS_SVH
`define BSPLINE_DE_BOOR_EVALUATOR_MACROS_SVH

// same-cycle implication
`define BDE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bde assertion failed");

// next-cycle implication
`define BDE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bde assertion failed");

`endif

[src/bde_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bde_pkg
// shared types, constants and helpers of the b-spline evaluator
// ----------------------------------------------------------------------------
package bde_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int MAX_DEGREE_DEF = 5;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int SATW           = 72;

  typedef enum logic [1:0] {
    FUNC_POINT = 2'd0,
    FUNC_KNOT  = 2'd1,
    FUNC_EVAL  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic {
    CFG_DEGREE      = 1'b0,
    CFG_POINT_COUNT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [6:0]         slot;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] knot_value;
    logic signed [31:0] eval_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [6:0]         span_index;
    logic               degenerate;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [SATW-1:0] v);
    logic signed [SATW-1:0] hi;
    logic signed [SATW-1:0] lo;
    hi = SATW'(64'sh7FFF_FFFF);
    lo = -SATW'(64'sh8000_0000);
    if (v > hi) return 32'sh7FFF_FFFF;
    else if (v < lo) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

endpackage

[src/bde_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bde_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bde_div #(
  parameter int NW = 49,
  parameter int DW = 33
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[NW-1]};
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = num;
      den_nxt  = den;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DW'(trial - {1'b0, den_r});
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

[src/bde_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bde_mac
// two-stage blend unit: left + floor(alpha * (right - left) / 2^frac)
// ----------------------------------------------------------------------------
module bde_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] alpha,
  input  logic signed [31:0] d_left,
  input  logic signed [31:0] d_right,
  output logic               done,
  output logic signed [31:0] result
);

  logic signed [32:0] diff;
  logic signed [64:0] prod_r;
  logic signed [31:0] left_r;
  logic signed [31:0] res_r;
  logic               v1_r, v2_r;
  logic signed [64:0] shifted;
  logic signed [65:0] sum;

  assign diff    = 33'(d_right) - 33'(d_left);
  assign shifted = prod_r >>> FRAC_BITS;
  assign sum     = 66'(shifted) + 66'(left_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
    end
    prod_r <= 65'(alpha) * 65'(diff);
    left_r <= d_left;
    res_r  <= bde_pkg::sat32(bde_pkg::SATW'(sum));
  end

  assign done   = v2_r;
  assign result = res_r;

endmodule

[src/bspline_de_boor_evaluator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspline_de_boor_evaluator
// 3-d non-uniform b-spline evaluator, de boor blend in q16.16
// ----------------------------------------------------------------------------
// Point and knot writes do not stall the input. An evaluation runs a span
// search of s steps (at most point_count - degree - 1), each with a single knot
// memory read, then T = p*(p+1)/2 blends, where p is the degree. Each blend runs
// the serial divider over NW = 33 + FRAC_BITS quotient bits, one bit per cycle;
// a zero knot difference skips the divider for that blend. The input is stalled
// while an evaluation runs; a finished result waits in an output register while
// the next item is taken.
module bspline_de_boor_evaluator #(
  parameter int MAX_POINTS = bde_pkg::MAX_POINTS_DEF,
  parameter int MAX_DEGREE = bde_pkg::MAX_DEGREE_DEF,
  parameter int FRAC_BITS  = bde_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bde_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output bde_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data
);

  localparam int KNOT_SLOTS = MAX_POINTS + MAX_DEGREE + 1;
  localparam int KW  = $clog2(KNOT_SLOTS);
  localparam int PW  = $clog2(MAX_POINTS);
  localparam int DGW = $clog2(MAX_DEGREE + 1);
  localparam int DEP = MAX_DEGREE + 1;
  localparam int NW  = 33 + FRAC_BITS;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_ENDS  = 15'b000000000000010,
    S_CLAMP = 15'b000000000000100,
    S_SRD   = 15'b000000000001000,
    S_SCMP  = 15'b000000000010000,
    S_LRD   = 15'b000000000100000,
    S_LWR   = 15'b000000001000000,
    S_BRD   = 15'b000000010000000,
    S_BDIV  = 15'b000000100000000,
    S_DWAIT = 15'b000001000000000,
    S_CRD   = 15'b000010000000000,
    S_CMUL  = 15'b000100000000000,
    S_CWAIT = 15'b001000000000000,
    S_FRD   = 15'b010000000000000,
    S_FOUT  = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0] degree_r;
  logic [6:0] point_count_r;

  // memories
  logic signed [31:0] knot_mem [KNOT_SLOTS];
  logic signed [31:0] cx_mem [MAX_POINTS];
  logic signed [31:0] cy_mem [MAX_POINTS];
  logic signed [31:0] cz_mem [MAX_POINTS];
  logic signed [31:0] dx_mem [DEP];
  logic signed [31:0] dy_mem [DEP];
  logic signed [31:0] dz_mem [DEP];

  logic [KW-1:0]  knot_ra, knot_rb;
  logic signed [31:0] knot_qa_r, knot_qb_r;
  logic [PW-1:0]  ctrl_ra;
  logic signed [31:0] cx_q_r, cy_q_r, cz_q_r;
  logic [DGW-1:0] d_ra, d_rb, d_wa;
  logic [2:0]     d_we;
  logic signed [31:0] d_wd;
  logic signed [31:0] dx_qa_r, dy_qa_r, dz_qa_r, dx_qb_r, dy_qb_r, dz_qb_r;

  // sequencer registers
  logic [DGW-1:0] p_r, p_nxt;
  logic [KW-1:0]  n_r, n_nxt;
  logic [KW-1:0]  k_r, k_nxt;
  logic [DGW-1:0] i_r, i_nxt;
  logic [DGW-1:0] rr_r, rr_nxt;
  logic [1:0]     c_r, c_nxt;
  logic signed [31:0] t_r, t_nxt;
  logic signed [31:0] ub_r, ub_nxt;
  logic signed [31:0] alpha_r, alpha_nxt;
  logic           neg_r, neg_nxt;
  logic           degen_r, degen_nxt;
  logic           outv_r, outv_nxt;
  bde_pkg::out_item_t out_r, out_nxt;

  int p_int, n_int;

  logic            accept;
  logic signed [32:0] sum_t, nd, den;
  logic [32:0]     nd_mag, den_mag;
  logic            div_start, div_done;
  logic [NW-1:0]   div_quo;
  logic signed [bde_pkg::SATW-1:0] quo_s;
  logic            mac_start, mac_done;
  logic signed [31:0] mac_res, mac_l, mac_r;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // effective degree and point count
  always_comb begin
    p_int = int'(degree_r);
    if (p_int < 1) p_int = 1;
    if (p_int > MAX_DEGREE) p_int = MAX_DEGREE;
    if (p_int > MAX_POINTS - 1) p_int = MAX_POINTS - 1;
    n_int = int'(point_count_r);
    if (n_int < p_int + 1) n_int = p_int + 1;
    if (n_int > MAX_POINTS) n_int = MAX_POINTS;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r      <= 3'd3;
      point_count_r <= 7'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        bde_pkg::CFG_DEGREE:      degree_r <= cfg_data[2:0];
        bde_pkg::CFG_POINT_COUNT: point_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stores
  always_ff @(posedge clk) begin
    if (accept && in_item.func == bde_pkg::FUNC_KNOT && 32'(in_item.slot) < KNOT_SLOTS) begin
      knot_mem[KW'(in_item.slot)] <= in_item.knot_value;
    end
    knot_qa_r <= knot_mem[knot_ra];
    knot_qb_r <= knot_mem[knot_rb];
  end

  always_ff @(posedge clk) begin
    if (accept && in_item.func == bde_pkg::FUNC_POINT && 32'(in_item.slot) < MAX_POINTS) begin
      cx_mem[PW'(in_item.slot)] <= in_item.point_x;
      cy_mem[PW'(in_item.slot)] <= in_item.point_y;
      cz_mem[PW'(in_item.slot)] <= in_item.point_z;
    end
    cx_q_r <= cx_mem[ctrl_ra];
    cy_q_r <= cy_mem[ctrl_ra];
    cz_q_r <= cz_mem[ctrl_ra];
  end

  // load path writes each channel from its own read register
  always_ff @(posedge clk) begin
    if (state_r == S_LWR) begin
      dx_mem[i_r] <= cx_q_r;
      dy_mem[i_r] <= cy_q_r;
      dz_mem[i_r] <= cz_q_r;
    end else begin
      if (d_we[0]) dx_mem[d_wa] <= d_wd;
      if (d_we[1]) dy_mem[d_wa] <= d_wd;
      if (d_we[2]) dz_mem[d_wa] <= d_wd;
    end
    dx_qa_r <= dx_mem[d_ra];
    dy_qa_r <= dy_mem[d_ra];
    dz_qa_r <= dz_mem[d_ra];
    dx_qb_r <= dx_mem[d_rb];
    dy_qb_r <= dy_mem[d_rb];
    dz_qb_r <= dz_mem[d_rb];
  end

  // shared units
  assign sum_t   = 33'(t_r) + 33'(knot_qa_r);
  assign nd      = 33'(ub_r) - 33'(knot_qa_r);
  assign den     = 33'(knot_qb_r) - 33'(knot_qa_r);
  assign nd_mag  = nd[32] ? 33'(-nd) : 33'(nd);
  assign den_mag = den[32] ? 33'(-den) : 33'(den);
  assign quo_s   = neg_r ? -bde_pkg::SATW'(div_quo) : bde_pkg::SATW'(div_quo);

  bde_div #(.NW(NW), .DW(33)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({nd_mag, FRAC_BITS'(0)}),
    .den   (den_mag),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    case (c_r)
      2'd0:    begin mac_r = dx_qa_r; mac_l = dx_qb_r; end
      2'd1:    begin mac_r = dy_qa_r; mac_l = dy_qb_r; end
      default: begin mac_r = dz_qa_r; mac_l = dz_qb_r; end
    endcase
  end

  bde_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mac_start),
    .alpha   (alpha_r),
    .d_left  (mac_l),
    .d_right (mac_r),
    .done    (mac_done),
    .result  (mac_res)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    p_nxt = p_r; n_nxt = n_r; k_nxt = k_r; i_nxt = i_r; rr_nxt = rr_r; c_nxt = c_r;
    t_nxt = t_r; ub_nxt = ub_r; alpha_nxt = alpha_r; neg_nxt = neg_r;
    degen_nxt = degen_r; outv_nxt = outv_r; out_nxt = out_r;
    knot_ra = '0; knot_rb = '0; ctrl_ra = '0;
    d_ra = '0; d_rb = '0; d_wa = '0; d_we = '0; d_wd = '0;
    div_start = 1'b0; mac_start = 1'b0;
    if (outv_r && !out_stall) outv_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept && in_item.func == bde_pkg::FUNC_EVAL) begin
          p_nxt     = DGW'(p_int);
          n_nxt     = KW'(n_int);
          t_nxt     = in_item.eval_time;
          degen_nxt = 1'b0;
          state_nxt = S_ENDS;
        end
      end
      S_ENDS: begin
        knot_ra   = KW'(p_r);
        knot_rb   = n_r;
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        ub_nxt = t_r;
        if (sum_t < 33'(knot_qa_r)) ub_nxt = knot_qa_r;
        else ub_nxt = sum_t[31:0];
        if (sum_t < 33'(knot_qa_r)) begin
          if (knot_qa_r > knot_qb_r) ub_nxt = knot_qb_r;
        end else if (sum_t > 33'(knot_qb_r)) begin
          ub_nxt = knot_qb_r;
        end
        k_nxt     = KW'(p_r);
        state_nxt = S_SRD;
      end
      S_SRD: begin
        knot_ra = KW'(k_r + 1'b1);
        if (k_r < KW'(n_r - 1'b1)) begin
          state_nxt = S_SCMP;
        end else begin
          i_nxt     = '0;
          state_nxt = S_LRD;
        end
      end
      S_SCMP: begin
        if (knot_qa_r < ub_r) begin
          k_nxt     = KW'(k_r + 1'b1);
          state_nxt = S_SRD;
        end else begin
          i_nxt     = '0;
          state_nxt = S_LRD;
        end
      end
      S_LRD: begin
        ctrl_ra   = PW'(k_r - KW'(p_r) + KW'(i_r));
        state_nxt = S_LWR;
      end
      S_LWR: begin
        d_wa = i_r;
        d_we = 3'b000;
        ctrl_ra = PW'(k_r - KW'(p_r) + KW'(i_r));
        state_nxt = S_LRD;
        if (i_r == p_r) begin
          rr_nxt    = DGW'(1);
          i_nxt     = p_r;
          state_nxt = S_BRD;
        end else begin
          i_nxt = DGW'(i_r + 1'b1);
        end
      end
      S_BRD: begin
        knot_ra   = KW'(KW'(i_r) + k_r - KW'(p_r));
        knot_rb   = KW'(KW'(i_r) + 1'b1 + k_r - KW'(rr_r));
        state_nxt = S_BDIV;
      end
      S_BDIV: begin
        c_nxt = 2'd0;
        if (den == '0) begin
          alpha_nxt = '0;
          degen_nxt = 1'b1;
          state_nxt = S_CRD;
        end else begin
          neg_nxt   = nd[32] ^ den[32];
          div_start = 1'b1;
          state_nxt = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (div_done) begin
          alpha_nxt = bde_pkg::sat32(quo_s);
          state_nxt = S_CRD;
        end
      end
      S_CRD: begin
        d_ra      = i_r;
        d_rb      = DGW'(i_r - 1'b1);
        state_nxt = S_CMUL;
      end
      S_CMUL: begin
        mac_start = 1'b1;
        state_nxt = S_CWAIT;
      end
      S_CWAIT: begin
        if (mac_done) begin
          d_wa = i_r;
          d_wd = mac_res;
          case (c_r)
            2'd0:    d_we = 3'b001;
            2'd1:    d_we = 3'b010;
            default: d_we = 3'b100;
          endcase
          if (c_r != 2'd2) begin
            c_nxt     = 2'(c_r + 1'b1);
            state_nxt = S_CRD;
          end else if (i_r > rr_r) begin
            i_nxt     = DGW'(i_r - 1'b1);
            state_nxt = S_BRD;
          end else if (rr_r < p_r) begin
            rr_nxt    = DGW'(rr_r + 1'b1);
            i_nxt     = p_r;
            state_nxt = S_BRD;
          end else begin
            state_nxt = S_FRD;
          end
        end
      end
      S_FRD: begin
        d_ra      = p_r;
        state_nxt = S_FOUT;
      end
      S_FOUT: begin
        d_ra = p_r;
        if (!outv_r || !out_stall) begin
          outv_nxt           = 1'b1;
          out_nxt.pos_x      = dx_qa_r;
          out_nxt.pos_y      = dy_qa_r;
          out_nxt.pos_z      = dz_qa_r;
          out_nxt.span_index = 7'(k_r);
          out_nxt.degenerate = degen_r;
          state_nxt          = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      outv_r  <= outv_nxt;
    end
    p_r <= p_nxt; n_r <= n_nxt; k_r <= k_nxt; i_r <= i_nxt; rr_r <= rr_nxt; c_r <= c_nxt;
    t_r <= t_nxt; ub_r <= ub_nxt; alpha_r <= alpha_nxt; neg_r <= neg_nxt;
    degen_r <= degen_nxt; out_r <= out_nxt;
  end

  assign out_valid = outv_r;
  assign out_item  = out_r;

endmodule

[src/bde_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bde_checker
// port-level checks of the b-spline evaluator, bound to the top level
// ----------------------------------------------------------------------------
`include "bspline_de_boor_evaluator_macros.svh"

module bde_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input bde_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_stall,
  input bde_pkg::out_item_t out_item
);

  `BDE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))
  `BDE_ASSERT_NEXT(a_eval_busy, in_valid && !in_stall && in_item.func == bde_pkg::FUNC_EVAL, in_stall)
  `BDE_ASSERT_NEXT(a_write_free, in_valid && !in_stall && in_item.func != bde_pkg::FUNC_EVAL, !in_stall)
  `BDE_ASSERT_NOW(a_out_rise, !$past(out_valid) && out_valid && $past(rst_n), $past(in_stall))

endmodule

bind bspline_de_boor_evaluator bde_checker u_bde_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
